@@ src/svf_pkg.sv @@
package svf_pkg;

    typedef enum logic [3:0] {
        OP_LD,
        OP_ST,
        OP_ADD,
        OP_SUB,
        OP_MULK,
        OP_MULQ,
        OP_WRAP,
        OP_LDX,
        OP_RND,
        OP_TRIM,
        OP_SQB,
        OP_SQL,
        OP_OUT,
        OP_END
    } op_t;

    typedef enum logic [2:0] {
        C_ALL,
        C_TWO,
        C_ONE,
        C_LOWF,
        C_BANDF
    } cond_t;

    typedef enum logic [2:0] {
        SS_C,
        SS_C3,
        SS_3,
        SS_BL,
        SS_LB,
        SS_OUT
    } shsel_t;

    typedef enum logic [2:0] {
        MS_X,
        MS_L,
        MS_Q,
        MS_B,
        MS_O,
        MS_TZ
    } modesel_t;

    typedef enum logic [1:0] {
        RM_FLOOR,
        RM_TZ,
        RM_HAWAY,
        RM_HUP
    } rmode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_RND2,
        S_TRIMST,
        S_SRCH,
        S_SQADJ,
        S_TRIMFIN
    } state_t;

    typedef logic [2:0] ridx_t;
    typedef logic [5:0] pc_t;

    localparam ridx_t R_BAND = 3'd0;
    localparam ridx_t R_LOW  = 3'd1;
    localparam ridx_t R_QT   = 3'd2;
    localparam ridx_t R_TERM = 3'd3;
    localparam ridx_t R_NB   = 3'd4;
    localparam ridx_t R_NL   = 3'd5;
    localparam int    RF_DEPTH = 6;

    localparam logic [2:0] CFG_CUTOFF = 3'd0;
    localparam logic [2:0] CFG_RES    = 3'd1;
    localparam logic [2:0] CFG_RMODES = 3'd2;
    localparam logic [2:0] CFG_FLAGS  = 3'd3;
    localparam logic [2:0] CFG_BFRAC  = 3'd4;
    localparam logic [2:0] CFG_LFRAC  = 3'd5;
    localparam logic [2:0] CFG_OPPREC = 3'd6;
    localparam logic [2:0] CFG_SQUANT = 3'd7;

    typedef struct packed {
        op_t      op;
        cond_t    cond;
        ridx_t    r;
        shsel_t   ss;
        modesel_t ms;
    } uop_t;

    function automatic logic [3:0] qn_of(input logic [1:0] sel);
        logic [3:0] q;
        case (sel)
            2'd0:    q = 4'd12;
            2'd1:    q = 4'd8;
            2'd2:    q = 4'd6;
            default: q = 4'd3;
        endcase
        return q;
    endfunction

    function automatic uop_t mk(input op_t o, input cond_t c, input ridx_t r = R_BAND,
                                input shsel_t s = SS_C, input modesel_t m = MS_X);
        uop_t u;
        u.op   = o;
        u.cond = c;
        u.r    = r;
        u.ss   = s;
        u.ms   = m;
        return u;
    endfunction

    // micro-program for one filter word
    function automatic uop_t prog_rom(input pc_t pc);
        uop_t u;
        case (pc)
            // resonance term
            6'd0:  u = mk(OP_LD,   C_ALL, R_BAND);
            6'd1:  u = mk(OP_TRIM, C_ALL);
            6'd2:  u = mk(OP_MULK, C_ALL);
            6'd3:  u = mk(OP_RND,  C_TWO, R_BAND, SS_C, MS_Q);
            6'd4:  u = mk(OP_MULQ, C_ALL);
            6'd5:  u = mk(OP_RND,  C_TWO, R_BAND, SS_3, MS_Q);
            6'd6:  u = mk(OP_RND,  C_ONE, R_BAND, SS_C3, MS_Q);
            6'd7:  u = mk(OP_ST,   C_ALL, R_QT);
            // low updated first
            6'd8:  u = mk(OP_LD,   C_LOWF, R_BAND);
            6'd9:  u = mk(OP_TRIM, C_LOWF);
            6'd10: u = mk(OP_MULK, C_LOWF);
            6'd11: u = mk(OP_RND,  C_LOWF, R_BAND, SS_BL, MS_B);
            6'd12: u = mk(OP_ADD,  C_LOWF, R_LOW);
            6'd13: u = mk(OP_WRAP, C_LOWF);
            6'd14: u = mk(OP_ST,   C_LOWF, R_NL);
            6'd15: u = mk(OP_LD,   C_LOWF, R_NL);
            6'd16: u = mk(OP_LD,   C_BANDF, R_LOW);
            // low feedback term
            6'd17: u = mk(OP_RND,  C_ALL, R_BAND, SS_LB, MS_TZ);
            6'd18: u = mk(OP_TRIM, C_ALL);
            6'd19: u = mk(OP_MULK, C_ALL);
            6'd20: u = mk(OP_RND,  C_ALL, R_BAND, SS_C, MS_L);
            6'd21: u = mk(OP_ST,   C_ALL, R_TERM);
            // new band
            6'd22: u = mk(OP_LDX,  C_ALL);
            6'd23: u = mk(OP_TRIM, C_ALL);
            6'd24: u = mk(OP_MULK, C_ALL);
            6'd25: u = mk(OP_RND,  C_ALL, R_BAND, SS_C, MS_X);
            6'd26: u = mk(OP_ADD,  C_ALL, R_BAND);
            6'd27: u = mk(OP_SUB,  C_ALL, R_TERM);
            6'd28: u = mk(OP_SUB,  C_ALL, R_QT);
            6'd29: u = mk(OP_WRAP, C_ALL);
            6'd30: u = mk(OP_ST,   C_ALL, R_NB);
            // band updated first: low from new band
            6'd31: u = mk(OP_LD,   C_BANDF, R_NB);
            6'd32: u = mk(OP_TRIM, C_BANDF);
            6'd33: u = mk(OP_MULK, C_BANDF);
            6'd34: u = mk(OP_RND,  C_BANDF, R_BAND, SS_BL, MS_B);
            6'd35: u = mk(OP_ADD,  C_BANDF, R_LOW);
            6'd36: u = mk(OP_WRAP, C_BANDF);
            6'd37: u = mk(OP_ST,   C_BANDF, R_NL);
            // store quantization and output
            6'd38: u = mk(OP_LD,   C_ALL, R_NB);
            6'd39: u = mk(OP_SQB,  C_ALL);
            6'd40: u = mk(OP_WRAP, C_ALL);
            6'd41: u = mk(OP_ST,   C_ALL, R_BAND);
            6'd42: u = mk(OP_LD,   C_ALL, R_NL);
            6'd43: u = mk(OP_SQL,  C_ALL);
            6'd44: u = mk(OP_WRAP, C_ALL);
            6'd45: u = mk(OP_ST,   C_ALL, R_LOW);
            6'd46: u = mk(OP_RND,  C_ALL, R_BAND, SS_OUT, MS_O);
            6'd47: u = mk(OP_OUT,  C_ALL);
            default: u = mk(OP_END, C_ALL);
        endcase
        return u;
    endfunction

endpackage

@@ src/svf_lowpass_fixed_point_core.sv @@
// Chamberlin state-variable low-pass filter in fixed point. A word on the slave
// stream with tuser set presets the band and low accumulators and gives no result;
// a word with tuser clear filters one 16-bit sample and gives one 32-bit output word
// (minus two times the low accumulator rounded to three fraction bits). All
// arithmetic runs through one shared 64-bit multiply/round/add unit stepped by a
// micro-program, so s_tready is low while a sample is in work. A filter word is
// accepted in the idle state and then runs 49 micro-steps, plus any wait on the
// output register; each of the four operand trims adds a leading-one search when
// operand_precision is nonzero, each of up to seven positive rounding shifts adds
// a second rounding state, and each enabled store quantization adds a trim (two
// when it rounds); the six-step leading-one search in the trim path is most of
// that extra work. A preset leaves the core idle. Configuration writes are taken
// at any time and must only be issued idle.
module svf_lowpass_fixed_point_core #(
    parameter int STATE_WIDTH = 40
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // sample_in[15:0], preset_band[39:16], preset_low[63:40]
    input  logic [0:0]  s_tuser,   // opcode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // mixed_out[31:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [13:0] cfg_data
);
    import svf_pkg::*;

    logic [13:0] cutoff_reg;
    logic [1:0]  res_reg;
    logic [9:0]  rmodes_reg;
    logic [2:0]  flags_reg;
    logic [3:0]  bfrac_reg;
    logic [3:0]  lfrac_reg;
    logic [5:0]  opprec_reg;
    logic [8:0]  squant_reg;

    state_t      state_reg, state_next;
    pc_t         pc_reg, pc_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] srch_reg, srch_next;
    logic        neg_reg, neg_next;
    logic [5:0]  pos_reg, pos_next;
    logic [2:0]  k_reg, k_next;
    logic [5:0]  tp_reg, tp_next;
    logic        sqr_reg, sqr_next;
    logic [5:0]  rsh_reg, rsh_next;
    rmode_t      rmode_reg, rmode_next;
    logic [15:0] sample_reg, sample_next;
    logic [31:0] out_reg, out_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] rf_reg [RF_DEPTH];

    logic        rf_we;
    logic        preset;
    uop_t        u;
    logic        cond_ok;
    logic [9:0]  coef_k;
    logic signed [7:0] coef_sh, fbb, fl, sh_val, sh_neg;
    rmode_t      mode;
    logic [9:0]  mul_b;
    logic [63:0] prod, rf_rd, acc_mag, half, rnd_r, trim_a, inc;
    logic [5:0]  s_r, cand;
    logic [6:0]  bl, bl_s;
    logic [3:0]  sq_p;

    function automatic logic [63:0] wrapw(input logic [63:0] v);
        logic [63:0] w;
        w = v;
        for (int i = 0; i < 64; i++) begin
            if (i >= STATE_WIDTH) begin
                w[i] = v[STATE_WIDTH-1];
            end
        end
        return w;
    endfunction

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;
    assign preset    = s_tvalid && s_tready && s_tuser[0];

    assign u       = prog_rom(pc_reg);
    assign coef_k  = flags_reg[0] ? {1'b1, cutoff_reg[8:0]} : {2'b01, cutoff_reg[8:1]};
    assign coef_sh = (flags_reg[0] ? 8'sd25 : 8'sd24) - $signed({3'b000, cutoff_reg[13:9]});
    assign fbb     = $signed({4'b0000, bfrac_reg});
    assign fl      = $signed({4'b0000, lfrac_reg});
    assign mul_b   = (u.op == OP_MULQ) ? {6'b000000, qn_of(res_reg)} : coef_k;
    assign prod    = acc_reg * 64'(mul_b);
    assign rf_rd   = rf_reg[u.r];
    assign acc_mag = acc_reg[63] ? (64'd0 - acc_reg) : acc_reg;
    assign sh_neg  = 8'sd0 - sh_val;
    assign s_r     = (sh_val > 8'sd63) ? 6'd63 : sh_val[5:0];
    assign half    = 64'd1 << (s_r - 6'd1);
    assign bl      = {1'b0, pos_reg} + 7'd1;
    assign bl_s    = bl - {1'b0, tp_reg};
    assign cand    = pos_reg | (6'd1 << k_reg);
    assign sq_p    = (u.op == OP_SQB) ? squant_reg[3:0] : squant_reg[7:4];

    always_comb
    begin
        case (u.cond)
            C_TWO:   cond_ok = flags_reg[1];
            C_ONE:   cond_ok = !flags_reg[1];
            C_LOWF:  cond_ok = flags_reg[2];
            C_BANDF: cond_ok = !flags_reg[2];
            default: cond_ok = 1'b1;
        endcase
        case (u.ss)
            SS_C:    sh_val = coef_sh;
            SS_C3:   sh_val = coef_sh + 8'sd3;
            SS_3:    sh_val = 8'sd3;
            SS_BL:   sh_val = coef_sh + fbb - fl;
            SS_LB:   sh_val = fl - fbb;
            default: sh_val = fl - 8'sd3;
        endcase
        case (u.ms)
            MS_X:    mode = rmode_t'(rmodes_reg[1:0]);
            MS_L:    mode = rmode_t'(rmodes_reg[3:2]);
            MS_Q:    mode = rmode_t'(rmodes_reg[5:4]);
            MS_B:    mode = rmode_t'(rmodes_reg[7:6]);
            MS_O:    mode = rmode_t'(rmodes_reg[9:8]);
            default: mode = RM_TZ;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        acc_next       = acc_reg;
        srch_next      = srch_reg;
        neg_next       = neg_reg;
        pos_next       = pos_reg;
        k_next         = k_reg;
        tp_next        = tp_reg;
        sqr_next       = sqr_reg;
        rsh_next       = rsh_reg;
        rmode_next     = rmode_reg;
        sample_next    = sample_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        rf_we          = 1'b0;
        rnd_r          = acc_reg >> rsh_reg;
        trim_a         = srch_reg;
        inc            = 64'd1 << bl_s[5:0];
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && !s_tuser[0])
                begin
                    sample_next = s_tdata[15:0];
                    pc_next     = '0;
                    state_next  = S_RUN;
                end
            end
            S_RUN:
            begin
                if (!cond_ok)
                begin
                    pc_next = pc_reg + 6'd1;
                end
                else
                begin
                    case (u.op)
                        OP_LD:
                        begin
                            acc_next = rf_rd;
                            pc_next  = pc_reg + 6'd1;
                        end
                        OP_ST:
                        begin
                            rf_we   = 1'b1;
                            pc_next = pc_reg + 6'd1;
                        end
                        OP_ADD:
                        begin
                            acc_next = acc_reg + rf_rd;
                            pc_next  = pc_reg + 6'd1;
                        end
                        OP_SUB:
                        begin
                            acc_next = acc_reg - rf_rd;
                            pc_next  = pc_reg + 6'd1;
                        end
                        OP_MULK, OP_MULQ:
                        begin
                            acc_next = prod;
                            pc_next  = pc_reg + 6'd1;
                        end
                        OP_WRAP:
                        begin
                            acc_next = wrapw(acc_reg);
                            pc_next  = pc_reg + 6'd1;
                        end
                        OP_LDX:
                        begin
                            acc_next = {{48{sample_reg[15]}}, sample_reg} << bfrac_reg;
                            pc_next  = pc_reg + 6'd1;
                        end
                        OP_RND:
                        begin
                            if (sh_val <= 8'sd0)
                            begin
                                // non-positive shift is a left shift
                                acc_next = (sh_neg > 8'sd63) ? 64'd0 : (acc_reg << sh_neg[5:0]);
                                pc_next  = pc_reg + 6'd1;
                            end
                            else
                            begin
                                neg_next   = acc_reg[63];
                                rsh_next   = s_r;
                                rmode_next = mode;
                                case (mode)
                                    RM_TZ:    acc_next = acc_mag;
                                    RM_HAWAY: acc_next = acc_mag + half;
                                    RM_HUP:   acc_next = acc_reg + half;
                                    default:  acc_next = acc_reg;
                                endcase
                                state_next = S_RND2;
                            end
                        end
                        OP_TRIM:
                        begin
                            if (opprec_reg == 6'd0)
                            begin
                                pc_next = pc_reg + 6'd1;
                            end
                            else
                            begin
                                tp_next    = opprec_reg;
                                sqr_next   = 1'b0;
                                state_next = S_TRIMST;
                            end
                        end
                        OP_SQB, OP_SQL:
                        begin
                            if (sq_p == 4'd0)
                            begin
                                pc_next = pc_reg + 6'd1;
                            end
                            else
                            begin
                                tp_next    = {2'b00, sq_p};
                                sqr_next   = squant_reg[8];
                                state_next = S_TRIMST;
                            end
                        end
                        OP_OUT:
                        begin
                            // hold until the output register is free
                            if (!out_valid_reg || m_tready)
                            begin
                                out_next       = 32'd0 - {acc_reg[30:0], 1'b0};
                                out_valid_next = 1'b1;
                                pc_next        = pc_reg + 6'd1;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RND2:
            begin
                if (rmode_reg == RM_FLOOR || rmode_reg == RM_HUP)
                begin
                    acc_next = $unsigned($signed(acc_reg) >>> rsh_reg);
                end
                else
                begin
                    acc_next = neg_reg ? (64'd0 - rnd_r) : rnd_r;
                end
                pc_next    = pc_reg + 6'd1;
                state_next = S_RUN;
            end
            S_TRIMST:
            begin
                srch_next  = acc_mag;
                neg_next   = acc_reg[63];
                pos_next   = '0;
                k_next     = 3'd5;
                state_next = S_SRCH;
            end
            S_SRCH:
            begin
                // binary search for the leading one of the magnitude
                if (((srch_reg | 64'd1) >> cand) != 64'd0)
                begin
                    pos_next = cand;
                end
                if (k_reg == 3'd0)
                begin
                    state_next = sqr_reg ? S_SQADJ : S_TRIMFIN;
                end
                else
                begin
                    k_next = k_reg - 3'd1;
                end
            end
            S_SQADJ:
            begin
                inc = 64'd1 << (bl_s[5:0] - 6'd1);
                if (bl > {1'b0, tp_reg})
                begin
                    acc_next = neg_reg ? (acc_reg - inc) : (acc_reg + inc);
                end
                sqr_next   = 1'b0;
                state_next = S_TRIMST;
            end
            S_TRIMFIN:
            begin
                if (bl > {1'b0, tp_reg})
                begin
                    trim_a = srch_reg & ~(inc - 64'd1);
                end
                acc_next   = neg_reg ? (64'd0 - trim_a) : trim_a;
                pc_next    = pc_reg + 6'd1;
                state_next = S_RUN;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
            sqr_reg       <= 1'b0;
            k_reg         <= '0;
            cutoff_reg    <= '0;
            res_reg       <= '0;
            rmodes_reg    <= '0;
            flags_reg     <= '0;
            bfrac_reg     <= 4'd3;
            lfrac_reg     <= 4'd3;
            opprec_reg    <= '0;
            squant_reg    <= '0;
            for (int i = 0; i < RF_DEPTH; i++)
            begin
                rf_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            sqr_reg       <= sqr_next;
            k_reg         <= k_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_CUTOFF: cutoff_reg <= cfg_data;
                    CFG_RES:    res_reg    <= cfg_data[1:0];
                    CFG_RMODES: rmodes_reg <= cfg_data[9:0];
                    CFG_FLAGS:  flags_reg  <= cfg_data[2:0];
                    CFG_BFRAC:  bfrac_reg  <= cfg_data[3:0];
                    CFG_LFRAC:  lfrac_reg  <= cfg_data[3:0];
                    CFG_OPPREC: opprec_reg <= cfg_data[5:0];
                    CFG_SQUANT: squant_reg <= cfg_data[8:0];
                    default:    ;
                endcase
            end
            if (preset)
            begin
                rf_reg[R_BAND] <= {{40{s_tdata[39]}}, s_tdata[39:16]};
                rf_reg[R_LOW]  <= {{40{s_tdata[63]}}, s_tdata[63:40]};
            end
            else if (rf_we)
            begin
                rf_reg[u.r] <= acc_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        srch_reg   <= srch_next;
        neg_reg    <= neg_next;
        pos_reg    <= pos_next;
        tp_reg     <= tp_next;
        rsh_reg    <= rsh_next;
        rmode_reg  <= rmode_next;
        sample_reg <= sample_next;
        out_reg    <= out_next;
    end

endmodule
